// ===== design/tksa_pkg.sv =====
// Shared word types and event codes for the terminal key decoder.
package tksa_pkg;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_EMPTY = 2'd1;
    localparam logic [1:0] OP_LEFT  = 2'd2;
    localparam logic [1:0] OP_RIGHT = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] in_byte;
    } in_word_t;

    typedef struct packed {
        logic [6:0] key_code;
        logic       quit;
    } out_word_t;

endpackage

// ===== design/tksa_in_stage.sv =====
// Input register stage that holds one accepted event word.
module tksa_in_stage
    import tksa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    input  logic     advance,
    output logic     held_valid,
    output in_word_t held_word
);

    logic     valid_reg;
    in_word_t word_reg;

    // The stage frees up in the same cycle its word moves on.
    assign s_ready    = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_data;
        end
    end

endmodule

// ===== design/tksa_decoder.sv =====
// Decode mode register and translation of one event into a key code.
module tksa_decoder
    import tksa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  in_word_t  in_word,
    output out_word_t result
);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_C2   = 3'd2,
        MODE_C3   = 3'd3,
        MODE_SKIP = 3'd4
    } mode_t;

    localparam logic [7:0] BYTE_ESC  = 8'h1B;
    localparam logic [7:0] BYTE_DEL  = 8'h7F;
    localparam logic [7:0] BYTE_BS   = 8'h08;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_LEAD2 = 8'hC2;
    localparam logic [7:0] BYTE_LEAD3 = 8'hC3;

    mode_t      mode_reg, mode_next;
    logic [1:0] skip_left_reg, skip_left_next;
    logic [1:0] skip_dec;
    logic       is_byte;
    logic [7:0] b;

    function automatic logic [6:0] map_esc(input logic [7:0] ch);
        logic [6:0] code;
        case (ch)
            8'h34:        code = 7'h24;
            8'h65, 8'h45: code = 7'h60;
            8'h75, 8'h55: code = 7'h7E;
            default:      code = 7'h00;
        endcase
        return code;
    endfunction

    function automatic logic [6:0] map_c3(input logic [7:0] ch);
        logic [6:0] code;
        case (ch)
            8'hA4:   code = 7'h7B;
            8'hB6:   code = 7'h7C;
            8'hA5:   code = 7'h7D;
            8'h84:   code = 7'h5B;
            8'h96:   code = 7'h5C;
            8'h85:   code = 7'h5D;
            8'hA9:   code = 7'h60;
            8'h9C:   code = 7'h5E;
            8'hBC:   code = 7'h7E;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

    assign is_byte  = (in_word.op == OP_BYTE);
    assign b        = in_word.in_byte;
    assign skip_dec = (skip_left_reg != 2'd0) ? skip_left_reg - 2'd1 : skip_left_reg;

    always_comb begin
        mode_next       = mode_reg;
        skip_left_next  = skip_left_reg;
        result.key_code = 7'h00;
        result.quit     = 1'b0;
        unique case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_IDLE;
                if (in_word.op == OP_EMPTY) begin
                    result.quit = 1'b1;
                end else if (is_byte) begin
                    result.key_code = map_esc(b);
                end
            end
            MODE_C2: begin
                mode_next = MODE_IDLE;
                if (is_byte && b == 8'hA4) begin
                    result.key_code = 7'h24;
                end
            end
            MODE_C3: begin
                mode_next = MODE_IDLE;
                if (is_byte) begin
                    result.key_code = map_c3(b);
                end
            end
            MODE_SKIP: begin
                // Every event counts here, empty polls and cursor keys too.
                skip_left_next = skip_dec;
                if (skip_dec == 2'd0) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                // Unused mode codes behave as idle.
                mode_next      = MODE_IDLE;
                skip_left_next = 2'd0;
                if (is_byte) begin
                    case (b) inside
                        BYTE_ESC:           mode_next = MODE_ESC;
                        BYTE_DEL, BYTE_BS:  result.key_code = 7'h08;
                        BYTE_LF, BYTE_CR:   result.key_code = 7'h0D;
                        BYTE_LEAD2:         mode_next = MODE_C2;
                        BYTE_LEAD3:         mode_next = MODE_C3;
                        [8'hE2:8'hEF]: begin
                            mode_next      = MODE_SKIP;
                            skip_left_next = 2'd2;
                        end
                        [8'hF0:8'hF3]: begin
                            mode_next      = MODE_SKIP;
                            skip_left_next = 2'd3;
                        end
                        [8'h20:8'h7E]:      result.key_code = b[6:0];
                        default:            result.key_code = 7'h00;
                    endcase
                end else if (in_word.op == OP_LEFT) begin
                    result.key_code = 7'h08;
                end else if (in_word.op == OP_RIGHT) begin
                    result.key_code = 7'h09;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            skip_left_reg <= 2'd0;
        end else if (advance) begin
            mode_reg      <= mode_next;
            skip_left_reg <= skip_left_next;
        end
    end

`ifndef SYNTHESIS
    a_esc_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && mode_reg == MODE_ESC) |=> (mode_reg == MODE_IDLE))
        else $error("ESC pending mode did not end after one word");

    a_skip_only_in_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_SKIP) |-> (skip_left_reg == 2'd0))
        else $error("discard count left over outside discard mode");

    a_quit_from_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result.quit) |-> (mode_reg == MODE_ESC && result.key_code == 7'h00))
        else $error("quit raised outside ESC pending mode");
`endif

endmodule

// ===== design/tksa_out_stage.sv =====
// Result register stage that holds one decoded word until it is taken.
module tksa_out_stage
    import tksa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  out_word_t load_word,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic      valid_reg;
    out_word_t word_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= load_word;
        end
    end

endmodule

// ===== design/terminal_key_to_swedish_ascii.sv =====
// An accepted word waits in the input register until the result register can take it;
// its decoded result is then loaded there and driven on m_data until it is taken.
// Throughput: one word per cycle while m_ready is high; each register holds one word.
// The decode mode advances only when a word moves from the input to the result register.
// Reset: aresetn is synchronous and active low; it empties both registers,
// returns the decode mode to idle and clears the discard count.
// Top level of the terminal key decoder for the Swedish 7-bit code set.
module terminal_key_to_swedish_ascii
    import tksa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic      held_valid;
    in_word_t  held_word;
    logic      can_load;
    logic      advance;
    out_word_t result;

    assign advance = held_valid && can_load;

    tksa_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    tksa_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_word (held_word),
        .result  (result)
    );

    tksa_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .load_word (result),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (held_valid && m_valid && !m_ready))
        else $error("input stalled while a register was free");

    a_word_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("decoded word lost on its way to the result register");
`endif

endmodule
